// ===== src/pal_pkg.sv =====
// Shared types and constants for the positional array list unit.
// Depends on nothing; imported by pal_dp, pal_ctrl and positional_array_list_unit.
`timescale 1ns / 1ps

package pal_pkg;

	// list storage geometry
	localparam int DEPTH = 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int VAL_W = 32;
	localparam int POS_W = 8;

	// request kinds
	typedef enum logic [1:0] {
		REQ_VISIT  = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic check;
		logic read;
		logic grab;
		logic walk;
		logic put;
		logic commit;
	} pal_cmd_t;

	// datapath to controller status
	typedef struct packed {
		req_t kind;
		logic refuse;
		logic walk_done;
		logic hit;
	} pal_stat_t;

endpackage

// ===== src/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/pal_dp.sv =====
// Datapath of the positional array list: request registers, entry count,
// walk pointer, list RAM and result registers. Depends on pal_pkg, pal_ram.
`timescale 1ns / 1ps

module pal_dp
	import pal_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  pal_cmd_t                cmd,
	output pal_stat_t               st,
	input  logic [1:0]              req_type,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    ok,
	output logic signed [VAL_W-1:0] read_value,
	output logic [POS_W-1:0]        found_position,
	output logic [POS_W-1:0]        entry_count,
	output logic                    is_empty,
	output logic                    is_full
);

	// request word
	req_t               kind_q;
	logic [POS_W-1:0]   pos_q;
	logic [VAL_W-1:0]   val_q;

	// list state and walk control
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      rptr_q;
	logic [CW-1:0]      moves_q;
	logic               pend_s1;
	logic [AW-1:0]      waddr_s1;
	logic [AW-1:0]      spos_s1;

	// per-request results
	logic               ok_q;
	logic [VAL_W-1:0]   rd_q;
	logic [POS_W-1:0]   found_q;

	// RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	logic [POS_W-1:0]   pos_m1;
	logic [POS_W-1:0]   lim;
	logic [POS_W-1:0]   idx_c;
	logic               refuse;
	logic               hit;
	logic [CW-1:0]      cnt_n;

	// clamp the position to the last entry, or to the append slot for insert
	assign pos_m1 = pos_q - POS_W'(1);
	assign lim    = (kind_q == REQ_INSERT) ? POS_W'(count_q) : POS_W'(count_q) - POS_W'(1);
	assign idx_c  = (pos_m1 > lim) ? lim : pos_m1;

	// refusal rules
	always_comb begin
		case (kind_q)
			REQ_VISIT:  refuse = (pos_q == '0) || (count_q == '0);
			REQ_DELETE: refuse = (pos_q == '0) || (count_q == '0);
			REQ_INSERT: refuse = (pos_q == '0) || (count_q == CW'(DEPTH));
			default:    refuse = 1'b0;
		endcase
	end

	// search compare on the word coming back from the RAM
	assign hit = cmd.walk && pend_s1 && (kind_q == REQ_SEARCH) && (ram_rdata == val_q);

	assign st.kind      = kind_q;
	assign st.refuse    = refuse;
	assign st.walk_done = (moves_q == '0) && !pend_s1;
	assign st.hit       = hit;

	// RAM addressing: walk pointer, or the clamped slot for a single access
	assign ram_raddr = cmd.read ? idx_q : rptr_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		if (cmd.walk && pend_s1 && (kind_q != REQ_SEARCH)) begin
			ram_we = 1'b1;
		end else if (cmd.put) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			ram_wdata = val_q;
		end
	end

	pal_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capture the request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_t'(req_type);
			pos_q  <= position;
			val_q  <= value;
		end
	end

	// set up the walk and the per-request results
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			idx_q   <= AW'(idx_c);
			ok_q    <= !refuse && (kind_q != REQ_SEARCH);
			rd_q    <= '0;
			found_q <= '0;
			if (kind_q == REQ_SEARCH) begin
				rptr_q  <= '0;
				moves_q <= count_q;
			end else begin
				rptr_q  <= AW'(count_q - CW'(1));
				moves_q <= CW'(POS_W'(count_q) - idx_c);
			end
		end else if (cmd.grab) begin
			rd_q    <= ram_rdata;
			rptr_q  <= idx_q + AW'(1);
			moves_q <= count_q - CW'(idx_q) - CW'(1);
		end else if (cmd.walk) begin
			if (hit) begin
				ok_q    <= 1'b1;
				found_q <= POS_W'(spos_s1) + POS_W'(1);
			end
			if (moves_q != '0) begin
				moves_q <= moves_q - CW'(1);
				rptr_q  <= (kind_q == REQ_INSERT) ? rptr_q - AW'(1) : rptr_q + AW'(1);
			end
		end
	end

	// read-to-write pipeline stage of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (cmd.walk) begin
			pend_s1 <= (moves_q != '0);
		end else begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			spos_s1  <= rptr_q;
			waddr_s1 <= (kind_q == REQ_INSERT) ? rptr_q + AW'(1) : rptr_q - AW'(1);
		end
	end

	// entry count after the request
	always_comb begin
		cnt_n = count_q;
		if (ok_q && (kind_q == REQ_INSERT)) begin
			cnt_n = count_q + CW'(1);
		end else if (ok_q && (kind_q == REQ_DELETE)) begin
			cnt_n = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= cnt_n;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok             <= ok_q;
			read_value     <= rd_q;
			found_position <= found_q;
			entry_count    <= POS_W'(cnt_n);
			is_empty       <= (cnt_n == '0);
			is_full        <= (cnt_n == CW'(DEPTH));
		end
	end

endmodule

// ===== src/pal_ctrl.sv =====
// Controller of the positional array list: request sequencing and the
// input and output handshakes. Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_ctrl
	import pal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pal_stat_t st,
	output pal_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_READ  = 7'b0000100,
		S_GRAB  = 7'b0001000,
		S_WALK  = 7'b0010000,
		S_PUT   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (st.refuse) begin
					state_n = S_DONE;
				end else if ((st.kind == REQ_VISIT) || (st.kind == REQ_DELETE)) begin
					state_n = S_READ;
				end else begin
					state_n = S_WALK;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_n  = S_GRAB;
			end
			S_GRAB: begin
				cmd.grab = 1'b1;
				state_n  = (st.kind == REQ_DELETE) ? S_WALK : S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (st.hit) begin
					state_n = S_DONE;
				end else if (st.walk_done) begin
					state_n = (st.kind == REQ_INSERT) ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("accepted word did not enter the check step");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result committed over an untaken word");

	a_hit_only_search: assert property (@(posedge clk) disable iff (!arst_n)
		st.hit |-> ((state_q == S_WALK) && (st.kind == REQ_SEARCH)))
		else $error("match flagged outside a search walk");

	a_put_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (st.kind == REQ_INSERT))
		else $error("final write outside an insert");

endmodule

// ===== src/positional_array_list_unit.sv =====
// Positional array list: up to 64 signed 32-bit entries with visit, search,
// insert and delete by 1-based position, result on its own channel.
// Depends on pal_pkg, pal_ctrl, pal_dp.
//
//   Input channel in_valid/in_ready carries one request word (req_type,
//   position, value). Output channel out_valid/out_ready carries one result
//   word (ok, read_value, found_position, entry_count, is_empty, is_full)
//   for each request, in order.
//   One request is worked at a time; in_ready is high only while the
//   controller is idle. A refused request goes from the check step
//   straight to the result; a visit reads its slot; a search walks the
//   entries from the first up to the first match; an insert shifts the
//   entries from the last down to the slot up by one, then writes its
//   value; a delete reads its slot, then shifts the later entries down.
//   The single RAM read port sets the pace: a shift or a search visits
//   one stored entry per cycle.
//   The result word sits in an output register; the next request is taken
//   while it waits, and is held in its final step until the word is taken.
//   Reset empties the list and drops any pending result; list storage is
//   not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps

module positional_array_list_unit
	import pal_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    ok,
	output logic signed [VAL_W-1:0] read_value,
	output logic [POS_W-1:0]        found_position,
	output logic [POS_W-1:0]        entry_count,
	output logic                    is_empty,
	output logic                    is_full
);

	pal_cmd_t  cmd;
	pal_stat_t st;

	// sequencing
	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// storage and result path
	pal_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.req_type       (req_type),
		.position       (position),
		.value          (value),
		.ok             (ok),
		.read_value     (read_value),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_empty       (is_empty),
		.is_full        (is_full)
	);

endmodule
